>>> rtl/sisf_pkg.sv
`timescale 1ns / 1ps
package sisf_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int CFG_CW      = 21;
   localparam int CFG_REG_W   = 3 * CFG_CW;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_NUM    = 8;
   localparam int CSR_IDX_W  = $clog2(CSR_NUM);
   localparam int CSR_ADDR_W = CSR_IDX_W + 3;

   localparam int FUNC_W = 3;
   localparam int VAL_W  = 32;
   localparam int Q_W    = 32;
   localparam int FRAC   = 16;

   // normal is brought into 15-bit range before the reflection math
   localparam int M_W   = 15;
   localparam int K_MAX = COORD_WIDTH - M_W;
   localparam int K_W   = $clog2(K_MAX + 1);

   localparam int NN_W  = 2 * M_W + 2;
   localparam int ND_W  = M_W + COORD_WIDTH + 2;
   localparam int R_W   = ND_W + M_W + 2;
   localparam int DP_W  = COORD_WIDTH + 1;
   localparam int W_W   = DP_W + CFG_CW + 1;
   localparam int C_W   = 2 * CFG_CW + 1;

   // operand split for the wide dot products
   localparam int AL    = R_W / 2;
   localparam int WL    = W_W / 2;
   localparam int CL    = C_W / 2;
   localparam int PPN_W = AL + WL + 2;
   localparam int PPD_W = AL + CL + 2;
   localparam int PN_W  = R_W + W_W;
   localparam int PD_W  = R_W + C_W;
   localparam int NUM_W = PN_W + 2;
   localparam int DEN_W = PD_W + 2;
   localparam int DIV_W = NUM_W + Q_W + 1;

   localparam int DOT_W  = CFG_CW + COORD_WIDTH + 2;
   localparam int DOT_SH = 8;

   localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W-1:0] SCALE_ONE = VAL_W'(1) << FRAC;

   localparam logic [1:0] KIND_POLY     = 2'd1;
   localparam logic [1:0] KIND_RATIONAL = 2'd2;

   localparam logic [FUNC_W-1:0] FN_NONE      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_REFLECT   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_HIGHLIGHT = 3'd2;
   localparam logic [FUNC_W-1:0] FN_LIGHT     = 3'd3;
   localparam logic [FUNC_W-1:0] FN_SECTION   = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VALUE_FUNC, CSR_STRIPE_FUNC, CSR_STRIPE_SCALE, CSR_REF_ORIGIN,
      CSR_REF_DIR_ONE, CSR_REF_DIR_TWO, CSR_LIGHT_DIR, CSR_SECTION_DIR
   } csr_idx_type;

   // pipeline stage positions
   localparam int ST_S2   = 1;
   localparam int ST_S3   = 2;
   localparam int ST_S4   = 3;
   localparam int ST_S5   = 4;
   localparam int ST_S6   = 5;
   localparam int ST_S7   = 6;
   localparam int ST_S8   = 7;
   localparam int ST_DIV  = 8;
   localparam int ST_VAL  = ST_DIV + Q_W + 1;
   localparam int ST_PROD = ST_VAL + 1;
   localparam int ST_OUT  = ST_PROD + 1;
   localparam int NS      = ST_OUT + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic                     action;
      logic [FUNC_W-1:0]        func;
      logic                     kind_ok;
      logic signed [VAL_W-1:0]  dot;
   } meta_type;

   typedef struct packed {
      logic neg;
      logic nneg;
      logic dz;
      logic nz;
      logic ovf;
   } divf_type;

   function automatic logic signed [CFG_CW-1:0] comp(input logic [CFG_REG_W-1:0] r,
                                                     input int i);
      return $signed(r[i*CFG_CW +: CFG_CW]);
   endfunction

endpackage

>>> rtl/surface_interrogation_shape_function_core.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; 44 register
// stages, 32 of them one restoring-divide step each.
// Bubbles collapse, so a stalled output still lets upstream stages fill.
// Reset (synchronous, active high) clears all valid bits and the configuration registers.
module surface_interrogation_shape_function_core
   import sisf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [1:0]              req_obj_kind,
   input  coord_type               req_ray_dx,
   input  coord_type               req_ray_dy,
   input  coord_type               req_ray_dz,
   input  coord_type               req_normal_x,
   input  coord_type               req_normal_y,
   input  coord_type               req_normal_z,
   input  coord_type               req_hit_x,
   input  coord_type               req_hit_y,
   input  coord_type               req_hit_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_shape_value,
   output logic                    rsp_stripe,
   output logic                    rsp_status,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // ---------------- configuration registers ----------------
   logic [FUNC_W-1:0]    value_func_ff, stripe_func_ff;
   logic [VAL_W-1:0]     stripe_scale_ff;
   logic [CFG_REG_W-1:0] ref_origin_ff, ref_dir_one_ff, ref_dir_two_ff;
   logic [CFG_REG_W-1:0] light_dir_ff, section_dir_ff;
   logic                 csr_wr;
   csr_idx_type          csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         value_func_ff   <= FN_NONE;
         stripe_func_ff  <= FN_NONE;
         stripe_scale_ff <= SCALE_ONE;
         ref_origin_ff   <= '0;
         ref_dir_one_ff  <= '0;
         ref_dir_two_ff  <= '0;
         light_dir_ff    <= '0;
         section_dir_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_VALUE_FUNC:   value_func_ff   <= csr_pwdata[FUNC_W-1:0];
            CSR_STRIPE_FUNC:  stripe_func_ff  <= csr_pwdata[FUNC_W-1:0];
            CSR_STRIPE_SCALE: stripe_scale_ff <= csr_pwdata[VAL_W-1:0];
            CSR_REF_ORIGIN:   ref_origin_ff   <= csr_pwdata[CFG_REG_W-1:0];
            CSR_REF_DIR_ONE:  ref_dir_one_ff  <= csr_pwdata[CFG_REG_W-1:0];
            CSR_REF_DIR_TWO:  ref_dir_two_ff  <= csr_pwdata[CFG_REG_W-1:0];
            CSR_LIGHT_DIR:    light_dir_ff    <= csr_pwdata[CFG_REG_W-1:0];
            CSR_SECTION_DIR:  section_dir_ff  <= csr_pwdata[CFG_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_VALUE_FUNC:   csr_prdata = CSR_DATA_W'(value_func_ff);
         CSR_STRIPE_FUNC:  csr_prdata = CSR_DATA_W'(stripe_func_ff);
         CSR_STRIPE_SCALE: csr_prdata = CSR_DATA_W'(stripe_scale_ff);
         CSR_REF_ORIGIN:   csr_prdata = CSR_DATA_W'(ref_origin_ff);
         CSR_REF_DIR_ONE:  csr_prdata = CSR_DATA_W'(ref_dir_one_ff);
         CSR_REF_DIR_TWO:  csr_prdata = CSR_DATA_W'(ref_dir_two_ff);
         CSR_LIGHT_DIR:    csr_prdata = CSR_DATA_W'(light_dir_ff);
         CSR_SECTION_DIR:  csr_prdata = CSR_DATA_W'(section_dir_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = ~vld_ff[NS-1] | rsp_ready;
      for (int k = NS - 2; k >= 0; k--) en[k] = ~vld_ff[k] | en[k+1];
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) if (en[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // ---------------- stage 1: input register ----------------
   meta_type  s1_meta_ff;
   coord_type s1_v_ff [3];
   coord_type s1_n_ff [3];
   coord_type s1_p_ff [3];
   meta_type  s1_meta_in;

   always_comb begin
      s1_meta_in.action  = req_action;
      s1_meta_in.func    = req_action ? stripe_func_ff : value_func_ff;
      s1_meta_in.kind_ok = (req_obj_kind == KIND_POLY) || (req_obj_kind == KIND_RATIONAL);
      s1_meta_in.dot     = '0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_meta_ff <= s1_meta_in;
         s1_v_ff[0] <= req_ray_dx;   s1_v_ff[1] <= req_ray_dy;   s1_v_ff[2] <= req_ray_dz;
         s1_n_ff[0] <= req_normal_x; s1_n_ff[1] <= req_normal_y; s1_n_ff[2] <= req_normal_z;
         s1_p_ff[0] <= req_hit_x;    s1_p_ff[1] <= req_hit_y;    s1_p_ff[2] <= req_hit_z;
      end
   end

   // ---------------- stage 2: normal range shift, hit minus origin ----------------
   meta_type                s2_meta_ff;
   coord_type               s2_v_ff [3];
   coord_type               s2_n_ff [3];
   coord_type               s2_p_ff [3];
   logic signed [M_W-1:0]   s2_m_ff [3];
   logic signed [DP_W-1:0]  s2_dp_ff [3];
   logic signed [M_W-1:0]   m_in [3];
   logic signed [DP_W-1:0]  dp_in [3];
   logic [K_W-1:0]          k_in;
   logic                    fit_in;
   coord_type               nsh_in;

   always_comb begin
      k_in = K_W'(K_MAX);
      for (int s = K_MAX; s >= 0; s--) begin
         fit_in = 1'b1;
         for (int j = 0; j < 3; j++) begin
            nsh_in = s1_n_ff[j] >>> (M_W - 1 + s);
            if (!((&nsh_in) || (~|nsh_in))) fit_in = 1'b0;
         end
         if (fit_in) k_in = K_W'(s);
      end
      for (int j = 0; j < 3; j++) begin
         nsh_in   = s1_n_ff[j] >>> k_in;
         m_in[j]  = nsh_in[M_W-1:0];
         dp_in[j] = DP_W'(s1_p_ff[j]) - DP_W'(comp(ref_origin_ff, j));
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S2]) begin
         s2_meta_ff <= s1_meta_ff;
         s2_v_ff    <= s1_v_ff;
         s2_n_ff    <= s1_n_ff;
         s2_p_ff    <= s1_p_ff;
         s2_m_ff    <= m_in;
         s2_dp_ff   <= dp_in;
      end
   end

   // ---------------- stage 3: n.n, n.v, cross products, direction dot ----------------
   meta_type               s3_meta_ff;
   coord_type              s3_v_ff [3];
   coord_type              s3_n_ff [3];
   logic signed [M_W-1:0]  s3_m_ff [3];
   logic signed [NN_W-1:0] s3_nn_ff;
   logic signed [ND_W-1:0] s3_nd_ff;
   logic signed [W_W-1:0]  s3_w_ff [3];
   logic signed [C_W-1:0]  s3_c_ff [3];
   logic signed [NN_W-1:0] nn_in;
   logic signed [ND_W-1:0] nd_in;
   logic signed [W_W-1:0]  w_in [3];
   logic signed [C_W-1:0]  c_in [3];
   logic signed [DOT_W-1:0] dsum_in, dsh_in;
   logic [CFG_REG_W-1:0]   ddir_in;
   meta_type               s3_meta_in;

   always_comb begin
      nn_in   = '0;
      nd_in   = '0;
      dsum_in = '0;
      ddir_in = (s2_meta_ff.func == FN_LIGHT) ? light_dir_ff : section_dir_ff;
      for (int j = 0; j < 3; j++) begin
         nn_in   = nn_in + NN_W'(s2_m_ff[j]) * NN_W'(s2_m_ff[j]);
         nd_in   = nd_in + ND_W'(s2_m_ff[j]) * ND_W'(s2_v_ff[j]);
         dsum_in = dsum_in + DOT_W'(comp(ddir_in, j)) * DOT_W'(s2_p_ff[j]);
         w_in[j] = W_W'(s2_dp_ff[(j+1)%3]) * W_W'(comp(ref_dir_two_ff, (j+2)%3))
                 - W_W'(s2_dp_ff[(j+2)%3]) * W_W'(comp(ref_dir_two_ff, (j+1)%3));
         c_in[j] = C_W'(comp(ref_dir_one_ff, (j+1)%3)) * C_W'(comp(ref_dir_two_ff, (j+2)%3))
                 - C_W'(comp(ref_dir_one_ff, (j+2)%3)) * C_W'(comp(ref_dir_two_ff, (j+1)%3));
      end
      dsh_in     = dsum_in >>> DOT_SH;
      s3_meta_in = s2_meta_ff;
      if (dsh_in > DOT_W'(Q_MAX))      s3_meta_in.dot = Q_MAX;
      else if (dsh_in < DOT_W'(Q_MIN)) s3_meta_in.dot = Q_MIN;
      else                             s3_meta_in.dot = dsh_in[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[ST_S3]) begin
         s3_meta_ff <= s3_meta_in;
         s3_v_ff    <= s2_v_ff;
         s3_n_ff    <= s2_n_ff;
         s3_m_ff    <= s2_m_ff;
         s3_nn_ff   <= nn_in;
         s3_nd_ff   <= nd_in;
         s3_w_ff    <= w_in;
         s3_c_ff    <= c_in;
      end
   end

   // ---------------- stage 4: reflected direction (scaled by n.n) or the normal ----------------
   meta_type              s4_meta_ff;
   logic signed [R_W-1:0] s4_a_ff [3];
   logic signed [W_W-1:0] s4_w_ff [3];
   logic signed [C_W-1:0] s4_c_ff [3];
   logic signed [R_W-1:0] r_in [3];
   logic signed [R_W-1:0] a_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         r_in[j] = R_W'(s3_nn_ff) * R_W'(s3_v_ff[j])
                 - ((R_W'(s3_nd_ff) * R_W'(s3_m_ff[j])) <<< 1);
         a_in[j] = (s3_meta_ff.func == FN_REFLECT) ? r_in[j] : R_W'(s3_n_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S4]) begin
         s4_meta_ff <= s3_meta_ff;
         s4_a_ff    <= a_in;
         s4_w_ff    <= s3_w_ff;
         s4_c_ff    <= s3_c_ff;
      end
   end

   // ---------------- stage 5: partial products ----------------
   meta_type                s5_meta_ff;
   logic signed [PPN_W-1:0] s5_ppn_ff [3][4];
   logic signed [PPD_W-1:0] s5_ppd_ff [3][4];
   logic signed [PPN_W-1:0] ppn_in [3][4];
   logic signed [PPD_W-1:0] ppd_in [3][4];
   logic signed [AL:0]      al_in, ah_in;
   logic signed [WL:0]      wl_in, wh_in;
   logic signed [CL:0]      cl_in, ch_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         al_in = $signed({1'b0, s4_a_ff[j][AL-1:0]});
         ah_in = (AL+1)'($signed(s4_a_ff[j][R_W-1:AL]));
         wl_in = $signed({1'b0, s4_w_ff[j][WL-1:0]});
         wh_in = (WL+1)'($signed(s4_w_ff[j][W_W-1:WL]));
         cl_in = $signed({1'b0, s4_c_ff[j][CL-1:0]});
         ch_in = (CL+1)'($signed(s4_c_ff[j][C_W-1:CL]));
         ppn_in[j][0] = PPN_W'(ah_in) * PPN_W'(wh_in);
         ppn_in[j][1] = PPN_W'(ah_in) * PPN_W'(wl_in);
         ppn_in[j][2] = PPN_W'(al_in) * PPN_W'(wh_in);
         ppn_in[j][3] = PPN_W'(al_in) * PPN_W'(wl_in);
         ppd_in[j][0] = PPD_W'(ah_in) * PPD_W'(ch_in);
         ppd_in[j][1] = PPD_W'(ah_in) * PPD_W'(cl_in);
         ppd_in[j][2] = PPD_W'(al_in) * PPD_W'(ch_in);
         ppd_in[j][3] = PPD_W'(al_in) * PPD_W'(cl_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S5]) begin
         s5_meta_ff <= s4_meta_ff;
         s5_ppn_ff  <= ppn_in;
         s5_ppd_ff  <= ppd_in;
      end
   end

   // ---------------- stage 6: per-component products ----------------
   meta_type               s6_meta_ff;
   logic signed [PN_W-1:0] s6_prn_ff [3];
   logic signed [PD_W-1:0] s6_prd_ff [3];
   logic signed [PN_W-1:0] prn_in [3];
   logic signed [PD_W-1:0] prd_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prn_in[j] = (PN_W'(s5_ppn_ff[j][0]) <<< (AL + WL)) + (PN_W'(s5_ppn_ff[j][1]) <<< AL)
                   + (PN_W'(s5_ppn_ff[j][2]) <<< WL) + PN_W'(s5_ppn_ff[j][3]);
         prd_in[j] = (PD_W'(s5_ppd_ff[j][0]) <<< (AL + CL)) + (PD_W'(s5_ppd_ff[j][1]) <<< AL)
                   + (PD_W'(s5_ppd_ff[j][2]) <<< CL) + PD_W'(s5_ppd_ff[j][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S6]) begin
         s6_meta_ff <= s5_meta_ff;
         s6_prn_ff  <= prn_in;
         s6_prd_ff  <= prd_in;
      end
   end

   // ---------------- stage 7: numerator and denominator ----------------
   meta_type                s7_meta_ff;
   logic signed [NUM_W-1:0] s7_num_ff;
   logic signed [DEN_W-1:0] s7_den_ff;

   always_ff @(posedge clock) begin
      if (en[ST_S7]) begin
         s7_meta_ff <= s6_meta_ff;
         s7_num_ff  <= NUM_W'(s6_prn_ff[0]) + NUM_W'(s6_prn_ff[1]) + NUM_W'(s6_prn_ff[2]);
         s7_den_ff  <= DEN_W'(s6_prd_ff[0]) + DEN_W'(s6_prd_ff[1]) + DEN_W'(s6_prd_ff[2]);
      end
   end

   // ---------------- stage 8: signs and magnitudes ----------------
   meta_type                s8_meta_ff;
   divf_type                s8_flag_ff;
   logic [NUM_W-1:0]        s8_magn_ff, s8_magd_ff;
   logic signed [NUM_W-1:0] dext_in;
   divf_type                s8_flag_in;

   always_comb begin
      dext_in         = NUM_W'(s7_den_ff);
      s8_flag_in.nneg = s7_num_ff[NUM_W-1];
      s8_flag_in.neg  = s7_num_ff[NUM_W-1] ^ s7_den_ff[DEN_W-1];
      s8_flag_in.dz   = (s7_den_ff == '0);
      s8_flag_in.nz   = (s7_num_ff == '0);
      s8_flag_in.ovf  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en[ST_S8]) begin
         s8_meta_ff <= s7_meta_ff;
         s8_flag_ff <= s8_flag_in;
         s8_magn_ff <= s7_num_ff[NUM_W-1] ? -s7_num_ff : s7_num_ff;
         s8_magd_ff <= dext_in[NUM_W-1] ? -dext_in : dext_in;
      end
   end

   // ---------------- divider: entry then one quotient bit per stage ----------------
   logic [DIV_W-1:0] dv_r_ff    [Q_W+1];
   logic [NUM_W-1:0] dv_b_ff    [Q_W+1];
   logic [Q_W-1:0]   dv_q_ff    [Q_W+1];
   divf_type         dv_flag_ff [Q_W+1];
   meta_type         dv_meta_ff [Q_W+1];
   logic [DIV_W-1:0] dv_r0_in;
   divf_type         dv_flag0_in;

   // quotient of 2^32 or more saturates either sign
   always_comb begin
      dv_r0_in        = DIV_W'(s8_magn_ff) << FRAC;
      dv_flag0_in     = s8_flag_ff;
      dv_flag0_in.ovf = dv_r0_in >= (DIV_W'(s8_magd_ff) << Q_W);
   end

   always_ff @(posedge clock) begin
      if (en[ST_DIV]) begin
         dv_r_ff[0]    <= dv_r0_in;
         dv_b_ff[0]    <= s8_magd_ff;
         dv_q_ff[0]    <= '0;
         dv_flag_ff[0] <= dv_flag0_in;
         dv_meta_ff[0] <= s8_meta_ff;
      end
   end

   for (genvar e = 1; e <= Q_W; e++) begin : g_div
      localparam int SH = Q_W - e;
      logic [DIV_W-1:0] t_in, r_in;
      logic             ge_in;

      always_comb begin
         t_in  = DIV_W'(dv_b_ff[e-1]) << SH;
         ge_in = dv_r_ff[e-1] >= t_in;
         r_in  = ge_in ? dv_r_ff[e-1] - t_in : dv_r_ff[e-1];
      end

      always_ff @(posedge clock) begin
         if (en[ST_DIV+e]) begin
            dv_r_ff[e]    <= r_in;
            dv_b_ff[e]    <= dv_b_ff[e-1];
            dv_q_ff[e]    <= dv_q_ff[e-1] | (Q_W'(ge_in) << SH);
            dv_flag_ff[e] <= dv_flag_ff[e-1];
            dv_meta_ff[e] <= dv_meta_ff[e-1];
         end
      end
   end

   // ---------------- value select, rounding, saturation ----------------
   logic signed [VAL_W-1:0] vs_val_ff;
   logic                    vs_status_ff, vs_action_ff;
   logic signed [VAL_W-1:0] val_in;
   logic                    status_in;
   logic [Q_W:0]            qa_in;
   divf_type                fq_in;
   meta_type                mq_in;

   always_comb begin
      fq_in     = dv_flag_ff[Q_W];
      mq_in     = dv_meta_ff[Q_W];
      val_in    = '0;
      status_in = 1'b0;
      qa_in     = {1'b0, dv_q_ff[Q_W]} + (Q_W+1)'(|dv_r_ff[Q_W]);
      if (mq_in.kind_ok) begin
         case (mq_in.func)
            FN_REFLECT, FN_HIGHLIGHT: begin
               if (fq_in.dz) begin
                  status_in = 1'b1;
                  val_in    = fq_in.nz ? '0 : (fq_in.nneg ? Q_MIN : Q_MAX);
               end else if (fq_in.ovf) begin
                  val_in = fq_in.neg ? Q_MIN : Q_MAX;
               end else if (!fq_in.neg) begin
                  val_in = dv_q_ff[Q_W][Q_W-1] ? Q_MAX : $signed(dv_q_ff[Q_W]);
               end else begin
                  // negative quotient rounds toward minus infinity
                  val_in = (qa_in > ((Q_W+1)'(1) << (Q_W - 1))) ? Q_MIN
                         : -$signed(qa_in[Q_W-1:0]);
               end
            end
            FN_LIGHT, FN_SECTION: val_in = mq_in.dot;
            default: val_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_VAL]) begin
         vs_val_ff    <= val_in;
         vs_status_ff <= status_in;
         vs_action_ff <= mq_in.action;
      end
   end

   // ---------------- stripe scale product ----------------
   logic signed [2*VAL_W-1:0] pr_f_ff;
   logic signed [VAL_W-1:0]   pr_val_ff;
   logic                      pr_status_ff, pr_action_ff;

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         pr_f_ff      <= (2*VAL_W)'($signed(stripe_scale_ff)) * (2*VAL_W)'(vs_val_ff);
         pr_val_ff    <= vs_val_ff;
         pr_status_ff <= vs_status_ff;
         pr_action_ff <= vs_action_ff;
      end
   end

   // ---------------- output register ----------------
   logic signed [VAL_W-1:0]   out_val_ff;
   logic                      out_stripe_ff, out_status_ff, out_action_ff;
   logic signed [2*VAL_W:0]   g_in;
   logic                      odd_in;

   always_comb begin
      g_in   = ((2*VAL_W+1)'(1) <<< Q_W) - (2*VAL_W+1)'(pr_f_ff);
      odd_in = pr_f_ff[2*VAL_W-1] ? g_in[Q_W] : pr_f_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_val_ff    <= pr_val_ff;
         out_status_ff <= pr_status_ff;
         out_action_ff <= pr_action_ff;
         out_stripe_ff <= pr_action_ff & ~odd_in;
      end
   end

   assign rsp_valid       = vld_ff[NS-1];
   assign rsp_shape_value = out_val_ff;
   assign rsp_stripe      = out_stripe_ff;
   assign rsp_status      = out_status_ff;

   // ---------------- assertions ----------------
   a_status_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_shape_value == Q_MAX || rsp_shape_value == Q_MIN || rsp_shape_value == '0))
      else $error("status word with a non-saturated value");

   a_value_no_stripe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !out_action_ff) |-> !rsp_stripe)
      else $error("stripe bit on a value word");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> tb/sisf_checker.sv
`timescale 1ns / 1ps
module sisf_checker
   import sisf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_action,
   input  logic [1:0]              req_obj_kind,
   input  coord_type               req_ray_dx,
   input  coord_type               req_ray_dy,
   input  coord_type               req_ray_dz,
   input  coord_type               req_normal_x,
   input  coord_type               req_normal_y,
   input  coord_type               req_normal_z,
   input  coord_type               req_hit_x,
   input  coord_type               req_hit_y,
   input  coord_type               req_hit_z,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_shape_value,
   input  logic                    rsp_stripe,
   input  logic                    rsp_status,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      pending
);

   typedef logic signed [159:0] wide_type;

   typedef struct {
      logic signed [VAL_W-1:0] shape_value;
      logic                    stripe;
      logic                    status;
   } shade_type;

   shade_type expected_shades[$];

   logic [FUNC_W-1:0]    value_fn, stripe_fn;
   logic signed [31:0]   stripe_scale;
   logic [CFG_REG_W-1:0] origin_reg, dir1_reg, dir2_reg, light_reg, section_reg;

   assign pending = expected_shades.size();

   function automatic longint comp_of(input logic [CFG_REG_W-1:0] r, input int i);
      logic signed [CFG_CW-1:0] c;
      c = r[i*CFG_CW +: CFG_CW];
      return longint'(c);
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type x);
      if (x > wide_type'(Q_MAX)) return Q_MAX;
      if (x < wide_type'(Q_MIN)) return Q_MIN;
      return x[31:0];
   endfunction

   // floor(num * 2^16 / den), saturated; zero divisor flags
   function automatic logic signed [31:0] plane_ratio(input longint a[3], input longint p[3],
                                                      output logic dz);
      longint org[3], d1[3], d2[3], dp[3], w[3], c[3];
      wide_type num, den, an, ad;
      logic [199:0] ua, ub, q, rm;
      logic neg;
      for (int i = 0; i < 3; i++) begin
         org[i] = comp_of(origin_reg, i);
         d1[i]  = comp_of(dir1_reg, i);
         d2[i]  = comp_of(dir2_reg, i);
         dp[i]  = p[i] - org[i];
      end
      w[0] = dp[1] * d2[2] - dp[2] * d2[1];
      w[1] = dp[2] * d2[0] - dp[0] * d2[2];
      w[2] = dp[0] * d2[1] - dp[1] * d2[0];
      c[0] = d1[1] * d2[2] - d1[2] * d2[1];
      c[1] = d1[2] * d2[0] - d1[0] * d2[2];
      c[2] = d1[0] * d2[1] - d1[1] * d2[0];
      num = wide_type'(a[0]) * wide_type'(w[0]) + wide_type'(a[1]) * wide_type'(w[1])
          + wide_type'(a[2]) * wide_type'(w[2]);
      den = wide_type'(a[0]) * wide_type'(c[0]) + wide_type'(a[1]) * wide_type'(c[1])
          + wide_type'(a[2]) * wide_type'(c[2]);
      dz = 1'b0;
      if (den == 0) begin
         dz = 1'b1;
         if (num == 0) return '0;
         return (num < 0) ? Q_MIN : Q_MAX;
      end
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      ua = {40'd0, an} << 16;
      ub = {40'd0, ad};
      q  = ua / ub;
      rm = ua % ub;
      if (!neg) return (q > 200'(Q_MAX)) ? Q_MAX : q[31:0];
      if (rm != 0) q = q + 1;
      if (q > (200'd1 << 31)) return Q_MIN;
      return -$signed(q[32:0]);
   endfunction

   function automatic logic signed [31:0] dir_dot(input logic [CFG_REG_W-1:0] r,
                                                  input longint p[3]);
      longint s;
      s = comp_of(r, 0) * p[0] + comp_of(r, 1) * p[1] + comp_of(r, 2) * p[2];
      return sat32(wide_type'(s >>> DOT_SH));
   endfunction

   function automatic logic signed [31:0] shape_of(input logic [FUNC_W-1:0] fn,
                                                   input logic [1:0] kind,
                                                   input longint v[3], input longint n[3],
                                                   input longint p[3], output logic dz);
      longint m[3], r[3], nn, nd;
      dz = 1'b0;
      if (kind != KIND_POLY && kind != KIND_RATIONAL) return '0;
      case (fn)
         FN_REFLECT: begin
            m = n;
            while (m[0] < -16384 || m[0] > 16383 || m[1] < -16384 || m[1] > 16383 ||
                   m[2] < -16384 || m[2] > 16383)
               for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
            nn = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            nd = m[0] * v[0] + m[1] * v[1] + m[2] * v[2];
            for (int i = 0; i < 3; i++) r[i] = nn * v[i] - 2 * nd * m[i];
            return plane_ratio(r, p, dz);
         end
         FN_HIGHLIGHT: return plane_ratio(n, p, dz);
         FN_LIGHT:     return dir_dot(light_reg, p);
         FN_SECTION:   return dir_dot(section_reg, p);
         default:      return '0;
      endcase
   endfunction

   function automatic shade_type predict_shade();
      shade_type s;
      longint v[3], n[3], p[3], f;
      v = '{longint'(req_ray_dx), longint'(req_ray_dy), longint'(req_ray_dz)};
      n = '{longint'(req_normal_x), longint'(req_normal_y), longint'(req_normal_z)};
      p = '{longint'(req_hit_x), longint'(req_hit_y), longint'(req_hit_z)};
      s.stripe = 1'b0;
      if (!req_action) begin
         s.shape_value = shape_of(value_fn, req_obj_kind, v, n, p, s.status);
      end else begin
         s.shape_value = shape_of(stripe_fn, req_obj_kind, v, n, p, s.status);
         f = longint'(stripe_scale) * longint'(s.shape_value);
         if (f < 0) f = (64'sd1 <<< 32) - f;
         s.stripe = ~f[32];
      end
      return s;
   endfunction

   always @(posedge clock) begin
      shade_type got, want;
      if (reset) begin
         value_fn     <= FN_NONE;
         stripe_fn    <= FN_NONE;
         stripe_scale <= SCALE_ONE;
         origin_reg   <= '0;
         dir1_reg     <= '0;
         dir2_reg     <= '0;
         light_reg    <= '0;
         section_reg  <= '0;
         fail_count   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[CSR_ADDR_W-1:3]))
               CSR_VALUE_FUNC:   value_fn     <= csr_pwdata[FUNC_W-1:0];
               CSR_STRIPE_FUNC:  stripe_fn    <= csr_pwdata[FUNC_W-1:0];
               CSR_STRIPE_SCALE: stripe_scale <= csr_pwdata[31:0];
               CSR_REF_ORIGIN:   origin_reg   <= csr_pwdata[CFG_REG_W-1:0];
               CSR_REF_DIR_ONE:  dir1_reg     <= csr_pwdata[CFG_REG_W-1:0];
               CSR_REF_DIR_TWO:  dir2_reg     <= csr_pwdata[CFG_REG_W-1:0];
               CSR_LIGHT_DIR:    light_reg    <= csr_pwdata[CFG_REG_W-1:0];
               CSR_SECTION_DIR:  section_reg  <= csr_pwdata[CFG_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_shades.push_back(predict_shade());
         if (rsp_valid && rsp_ready) begin
            got.shape_value = rsp_shape_value;
            got.stripe      = rsp_stripe;
            got.status      = rsp_status;
            if (expected_shades.size() == 0) begin
               $display("%0t: unexpected word value=%0d stripe=%0b status=%0b",
                        $time, got.shape_value, got.stripe, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_shades.pop_front();
               if (got.shape_value !== want.shape_value || got.stripe !== want.stripe ||
                   got.status !== want.status) begin
                  $display("%0t: mismatch expected value=%0d stripe=%0b status=%0b",
                           $time, want.shape_value, want.stripe, want.status);
                  $display("%0t:          actual   value=%0d stripe=%0b status=%0b",
                           $time, got.shape_value, got.stripe, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/tb_surface_interrogation_shape_function_core.sv
`timescale 1ns / 1ps
module tb_surface_interrogation_shape_function_core;
   import sisf_pkg::*;

   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_PHASES    = 10;
   localparam int PHASE_WORDS   = 160;

   logic                    clock, reset;
   logic                    req_valid, req_ready, req_action;
   logic [1:0]              req_obj_kind;
   coord_type               req_ray_dx, req_ray_dy, req_ray_dz;
   coord_type               req_normal_x, req_normal_y, req_normal_z;
   coord_type               req_hit_x, req_hit_y, req_hit_z;
   logic                    rsp_valid, rsp_ready;
   logic signed [VAL_W-1:0] rsp_shape_value;
   logic                    rsp_stripe, rsp_status;
   logic                    csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata, csr_prdata;
   int                      fail_count, pending, cycles;
   int                      burst_left;

   surface_interrogation_shape_function_core DUT (.*);

   sisf_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: modes of always ready, random, long stalls, and mostly ready
   int stall_mode, mode_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
         mode_left <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(5, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 9) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx) << 3;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drop valid, let the last accepted word reach the checker, then wait it out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      int span;
      case ($urandom_range(0, 7))
         0: return coord_type'($urandom);
         1: case ($urandom_range(0, 3))
               0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
               1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
               2: return '0;
               default: return '1;
            endcase
         default: begin
            span = 1 << $urandom_range(4, 16);
            return coord_type'(int'($urandom_range(0, 2 * span)) - span);
         end
      endcase
   endfunction

   function automatic logic [CFG_CW-1:0] rand_comp();
      int span;
      if ($urandom_range(0, 4) == 0) return CFG_CW'($urandom);
      span = 1 << $urandom_range(2, 14);
      return CFG_CW'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_vec();
      return {1'b0, rand_comp(), rand_comp(), rand_comp()};
   endfunction

   task automatic send(input logic act, input logic [1:0] kind,
                       input coord_type vx, input coord_type vy, input coord_type vz,
                       input coord_type nx, input coord_type ny, input coord_type nz,
                       input coord_type px, input coord_type py, input coord_type pz);
      int gap;
      req_action   <= act;
      req_obj_kind <= kind;
      req_ray_dx   <= vx;
      req_ray_dy   <= vy;
      req_ray_dz   <= vz;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_hit_x    <= px;
      req_hit_y    <= py;
      req_hit_z    <= pz;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_random();
      logic [1:0] kind;
      kind = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3))
                                         : 2'($urandom_range(1, 2));
      send(1'($urandom_range(0, 1)), kind, rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord());
   endtask

   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type ONE  = 24'sd4096;

   initial begin
      logic [31:0] scale;
      reset = 1'b1;
      cycles = 0;
      burst_left = 8;
      req_valid = 1'b0;
      req_action = 1'b0;
      req_obj_kind = '0;
      {req_ray_dx, req_ray_dy, req_ray_dz} = '0;
      {req_normal_x, req_normal_y, req_normal_z} = '0;
      {req_hit_x, req_hit_y, req_hit_z} = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: function none gives zero, stripe of zero is set
      send(1'b0, KIND_POLY, CMAX, CMIN, ONE, ONE, ONE, ONE, CMAX, CMIN, '0);
      send(1'b1, KIND_RATIONAL, CMIN, CMAX, '1, CMIN, CMAX, '1, CMIN, CMAX, '1);
      drain();

      // zero divisor: dir one is zero, dir two is not
      csr_write(CSR_VALUE_FUNC, CSR_DATA_W'(FN_HIGHLIGHT));
      csr_write(CSR_STRIPE_FUNC, CSR_DATA_W'(FN_REFLECT));
      csr_write(CSR_REF_DIR_TWO, {1'b0, 21'd0, 21'd0, 21'd4096});
      csr_write(CSR_REF_DIR_ONE, '0);
      send(1'b0, KIND_POLY, ONE, '0, '0, '0, ONE, '0, '0, ONE, '0);
      send(1'b0, KIND_POLY, ONE, '0, '0, '0, ONE, '0, '0, -ONE, '0);
      send(1'b0, KIND_POLY, ONE, '0, '0, '0, ONE, '0, '0, '0, '0);
      send(1'b1, KIND_RATIONAL, ONE, ONE, '0, '0, '0, '0, ONE, ONE, ONE);
      drain();

      // proper plane, all four functions, other object kinds
      csr_write(CSR_REF_DIR_ONE, {1'b0, 21'd0, 21'd4096, 21'd0});
      csr_write(CSR_REF_ORIGIN, {1'b0, 21'd100, 21'h1FFFFF, 21'd7});
      csr_write(CSR_LIGHT_DIR, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
      csr_write(CSR_SECTION_DIR, {1'b0, 21'd4096, 21'd0, 21'd0});
      csr_write(CSR_STRIPE_SCALE, 64'h8000_0000);
      send(1'b0, KIND_POLY, ONE, -ONE, ONE, CMAX, CMIN, ONE, CMAX, CMIN, CMAX);
      send(1'b1, KIND_RATIONAL, -ONE, ONE, ONE, '0, '0, '0, ONE, ONE, ONE);
      send(1'b1, KIND_POLY, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, ONE, -ONE, ONE);
      send(1'b0, 2'd0, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      send(1'b1, 2'd3, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      drain();
      csr_write(CSR_VALUE_FUNC, CSR_DATA_W'(FN_LIGHT));
      csr_write(CSR_STRIPE_FUNC, CSR_DATA_W'(FN_SECTION));
      csr_write(CSR_STRIPE_SCALE, 64'h7FFF_FFFF);
      send(1'b0, KIND_POLY, '0, '0, '0, '0, '0, '0, CMIN, CMIN, CMIN);
      send(1'b0, KIND_RATIONAL, '0, '0, '0, '0, '0, '0, CMAX, CMIN, CMAX);
      send(1'b1, KIND_POLY, '0, '0, '0, '0, '0, '0, -ONE, '0, '0);
      send(1'b1, KIND_POLY, '0, '0, '0, '0, '0, '0, CMAX, '0, '0);
      drain();
      csr_write(CSR_VALUE_FUNC, 64'd5);
      csr_write(CSR_STRIPE_FUNC, 64'd7);
      send(1'b0, KIND_POLY, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      send(1'b1, KIND_POLY, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      drain();
      csr_write(CSR_STRIPE_FUNC, 64'd6);
      send(1'b1, KIND_RATIONAL, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: scale = 32'h8000_0000;
            1: scale = 32'h7FFF_FFFF;
            2: scale = '0;
            default: scale = $urandom;
         endcase
         csr_write(CSR_VALUE_FUNC,
                   CSR_DATA_W'((ph < 8) ? (ph % 5) : $urandom_range(0, 7)));
         csr_write(CSR_STRIPE_FUNC,
                   CSR_DATA_W'((ph < 8) ? ((ph + 2) % 5) : $urandom_range(0, 7)));
         csr_write(CSR_STRIPE_SCALE, CSR_DATA_W'(scale));
         csr_write(CSR_REF_ORIGIN, (ph == 9) ? {1'b0, {CFG_REG_W{1'b1}}} : rand_vec());
         csr_write(CSR_REF_DIR_ONE, rand_vec());
         csr_write(CSR_REF_DIR_TWO, rand_vec());
         csr_write(CSR_LIGHT_DIR, (ph == 8) ? {1'b0, {CFG_REG_W{1'b1}}} : rand_vec());
         csr_write(CSR_SECTION_DIR, rand_vec());
         for (int k = 0; k < PHASE_WORDS; k++) send_random();
         if (ph != NUM_PHASES - 1) begin
            req_valid <= 1'b0;
            drain();
         end
      end

      req_valid <= 1'b0;
      drain();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
